@@ src/serial_acia_registers_top_defines.svh @@
// assertion macros for the serial adapter register block
// no dependencies; included by modules that carry assertions
`ifndef SERIAL_ACIA_REGISTERS_TOP_DEFINES_SVH
`define SERIAL_ACIA_REGISTERS_TOP_DEFINES_SVH
`ifndef SYNTHESIS
`define SAR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sar assertion failed");
`define SAR_ASSERT_NR(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sar assertion failed");
`else
`define SAR_ASSERT(lbl, clk, rst_n, prop)
`define SAR_ASSERT_NR(lbl, clk, prop)
`endif
`endif

@@ src/sar_pkg.sv @@
// types and constants for the serial adapter register block
// no dependencies
`default_nettype none
package sar_pkg;

  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_TICK  = 2'd2;

  localparam logic [1:0] CFG_CHAR_CYCLES = 2'd0;
  localparam logic [1:0] CFG_IRQ_SELECT  = 2'd1;
  localparam logic [1:0] CFG_LF_TO_CR    = 2'd2;

  localparam int CFG_DATA_W = 16;
  localparam int WAIT_W     = 16;

  localparam logic [7:0] CTRL_TX_MASK = 8'h60;
  localparam logic [7:0] CTRL_TX_IRQ  = 8'h20;
  localparam logic [7:0] CTRL_RX_IRQ  = 8'h80;
  localparam logic [7:0] CHAR_LF      = 8'h0a;
  localparam logic [7:0] CHAR_CR      = 8'h0d;

  localparam logic [1:0] IRQ_SEL_RESET = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic       reg_select;
    logic [7:0] write_data;
    logic [7:0] elapsed_cycles;
    logic       rx_valid;
    logic [7:0] rx_char;
  } sar_in_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       tx_valid;
    logic [7:0] tx_char;
    logic       rx_taken;
    logic [1:0] interrupt_out;
  } sar_out_t;

endpackage
`default_nettype wire

@@ src/serial_acia_registers_top.sv @@
// serial adapter register block: bus read/write and time tick handling
// depends on sar_pkg and serial_acia_registers_top_defines.svh
//
//   channel  | direction | ports                        | payload
//   in_      | input     | in_valid, in_stall, in_word  | sar_in_t
//   out_     | output    | out_valid, out_stall, out_word | sar_out_t
//   cfg_     | input     | cfg_we, cfg_index, cfg_wdata | 16 bit data
//
// one word per cycle while in_stall is low: the whole step is flag logic and two 16 bit
// down counters, done between the input port and the result register
// the result is registered and valid in the cycle after accept
// rst_n is synchronous; result valid and all state but the result word clear to reset values
// in_stall is raised only while a result is held and out_stall is high
`default_nettype none
`include "serial_acia_registers_top_defines.svh"
module serial_acia_registers_top (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire sar_pkg::sar_in_t               in_word,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output sar_pkg::sar_out_t                   out_word,
  input  wire logic                           cfg_we,
  input  wire logic [1:0]                     cfg_index,
  input  wire logic [sar_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic [sar_pkg::WAIT_W-1:0] char_cycles_r;
  logic [1:0]                 irq_sel_r;
  logic                       lf_to_cr_r;

  logic [7:0]                 control_r, control_nxt;
  logic                       rx_full_r, rx_full_nxt;
  logic                       tx_empty_r, tx_empty_nxt;
  logic                       irq_flag_r, irq_flag_nxt;
  logic [7:0]                 tx_byte_r, tx_byte_nxt;
  logic [7:0]                 rx_byte_r, rx_byte_nxt;
  logic [sar_pkg::WAIT_W-1:0] tx_wait_r, tx_wait_nxt;
  logic [sar_pkg::WAIT_W-1:0] rx_wait_r, rx_wait_nxt;

  logic                       out_valid_r;
  sar_pkg::sar_out_t          out_word_r, res_nxt;

  logic                       in_acc;
  logic [sar_pkg::WAIT_W-1:0] elapsed_ext, tx_dec, rx_dec;
  logic [7:0]                 rx_conv;

  assign in_stall  = out_valid_r & out_stall;
  assign in_acc    = in_valid & ~in_stall;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  assign elapsed_ext = {{(sar_pkg::WAIT_W-8){1'b0}}, in_word.elapsed_cycles};
  assign tx_dec = (tx_wait_r > elapsed_ext) ? (tx_wait_r - elapsed_ext) : '0;
  assign rx_dec = (rx_wait_r > elapsed_ext) ? (rx_wait_r - elapsed_ext) : '0;
  assign rx_conv = (lf_to_cr_r && in_word.rx_char == sar_pkg::CHAR_LF) ?
                   sar_pkg::CHAR_CR : in_word.rx_char;

  always_comb begin
    control_nxt  = control_r;
    rx_full_nxt  = rx_full_r;
    tx_empty_nxt = tx_empty_r;
    irq_flag_nxt = irq_flag_r;
    tx_byte_nxt  = tx_byte_r;
    rx_byte_nxt  = rx_byte_r;
    tx_wait_nxt  = tx_wait_r;
    rx_wait_nxt  = rx_wait_r;
    res_nxt      = '0;
    unique case (in_word.action)
      sar_pkg::ACT_READ: begin
        if (!in_word.reg_select) begin
          res_nxt.read_data = {irq_flag_r, 5'b0, tx_empty_r, rx_full_r};
        end else begin
          res_nxt.read_data = rx_byte_r;
          irq_flag_nxt      = 1'b0;
          rx_full_nxt       = 1'b0;
          rx_wait_nxt       = char_cycles_r;
        end
      end
      sar_pkg::ACT_WRITE: begin
        if (!in_word.reg_select) begin
          control_nxt = in_word.write_data;
        end else begin
          tx_byte_nxt  = in_word.write_data;
          tx_wait_nxt  = char_cycles_r;
          irq_flag_nxt = 1'b0;
          tx_empty_nxt = 1'b0;
        end
      end
      sar_pkg::ACT_TICK: begin
        tx_wait_nxt = tx_dec;
        rx_wait_nxt = rx_dec;
        // a send takes the tick, receive only when nothing goes out
        priority if (tx_dec == '0 && !tx_empty_r) begin
          res_nxt.tx_valid = 1'b1;
          res_nxt.tx_char  = tx_byte_r;
          tx_empty_nxt     = 1'b1;
          if ((control_r & sar_pkg::CTRL_TX_MASK) == sar_pkg::CTRL_TX_IRQ) begin
            irq_flag_nxt          = 1'b1;
            res_nxt.interrupt_out = irq_sel_r;
          end
        end else if (rx_dec == '0 && !rx_full_r && in_word.rx_valid) begin
          rx_byte_nxt      = rx_conv;
          rx_full_nxt      = 1'b1;
          res_nxt.rx_taken = 1'b1;
          if ((control_r & sar_pkg::CTRL_RX_IRQ) != 8'h00) begin
            irq_flag_nxt          = 1'b1;
            res_nxt.interrupt_out = irq_sel_r;
          end
        end else begin
          res_nxt.rx_taken = 1'b0;
        end
      end
      default: begin
        res_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_cycles_r <= '0;
      irq_sel_r     <= sar_pkg::IRQ_SEL_RESET;
      lf_to_cr_r    <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sar_pkg::CFG_CHAR_CYCLES: char_cycles_r <= cfg_wdata;
        sar_pkg::CFG_IRQ_SELECT:  irq_sel_r     <= cfg_wdata[1:0];
        sar_pkg::CFG_LF_TO_CR:    lf_to_cr_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      control_r   <= '0;
      rx_full_r   <= 1'b0;
      tx_empty_r  <= 1'b1;
      irq_flag_r  <= 1'b0;
      tx_byte_r   <= '0;
      rx_byte_r   <= '0;
      tx_wait_r   <= '0;
      rx_wait_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_acc) begin
        control_r  <= control_nxt;
        rx_full_r  <= rx_full_nxt;
        tx_empty_r <= tx_empty_nxt;
        irq_flag_r <= irq_flag_nxt;
        tx_byte_r  <= tx_byte_nxt;
        rx_byte_r  <= rx_byte_nxt;
        tx_wait_r  <= tx_wait_nxt;
        rx_wait_r  <= rx_wait_nxt;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_word_r <= res_nxt;
    end
  end

  // result word and state move together, so a held result matches the flags
  `SAR_ASSERT(a_tx_sets_empty, clk, rst_n, (out_valid_r && out_word_r.tx_valid) |-> tx_empty_r)
  `SAR_ASSERT(a_rx_sets_full, clk, rst_n, (out_valid_r && out_word_r.rx_taken) |-> rx_full_r)
  `SAR_ASSERT(a_irq_sets_flag, clk, rst_n,
    (out_valid_r && out_word_r.interrupt_out != 2'd0) |-> irq_flag_r)
  `SAR_ASSERT(a_tick_no_grow, clk, rst_n,
    (in_acc && in_word.action == sar_pkg::ACT_TICK) |=>
    (tx_wait_r <= $past(tx_wait_r) && rx_wait_r <= $past(rx_wait_r)))
  `SAR_ASSERT(a_one_event, clk, rst_n, out_valid_r |-> !(out_word_r.tx_valid && out_word_r.rx_taken))
  `SAR_ASSERT_NR(a_reset_idle, clk, !rst_n |=> !out_valid_r)

endmodule
`default_nettype wire
